[design/pid_controller_clamped_macros.svh]
// Assertion macros for the clamped PID controller.
// No dependencies; included by the modules that carry checks.
`ifndef PID_CONTROLLER_CLAMPED_MACROS_SVH
`define PID_CONTROLLER_CLAMPED_MACROS_SVH

// same-cycle implication
`define PCC_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PCC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/pcc_pkg.sv]
// Shared types and constants of the clamped PID controller: register indexes,
// microcode word layout and the control program ROM. No dependencies.
package pcc_pkg;

  localparam int STEP_W = 4;
  localparam int REG_W  = 3;

  typedef logic [STEP_W-1:0] step_t;

  localparam logic [REG_W-1:0] REG_PROP_GAIN   = 3'd0;
  localparam logic [REG_W-1:0] REG_INTEG_GAIN  = 3'd1;
  localparam logic [REG_W-1:0] REG_DERIV_GAIN  = 3'd2;
  localparam logic [REG_W-1:0] REG_TIME_STEP   = 3'd3;
  localparam logic [REG_W-1:0] REG_INTEG_UPPER = 3'd4;
  localparam logic [REG_W-1:0] REG_INTEG_LOWER = 3'd5;
  localparam logic [REG_W-1:0] REG_OUT_UPPER   = 3'd6;
  localparam logic [REG_W-1:0] REG_OUT_LOWER   = 3'd7;

  localparam step_t ST_IDLE = step_t'(0);

  typedef enum logic [2:0] {
    WT_NONE,
    WT_IN,
    WT_MUL,
    WT_DIV,
    WT_OUT
  } wait_e;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD_ERR,
    OP_INTEG_ADD,
    OP_INTEG_CLAMP,
    OP_ACC_LOAD,
    OP_ACC_ADD,
    OP_DERIV_LOAD,
    OP_OUT_CLAMP,
    OP_EMIT
  } dp_op_e;

  typedef enum logic [1:0] {
    MS_ERR_TS,
    MS_KP_ERR,
    MS_KI_INTEG,
    MS_KD_DERIV
  } mul_sel_e;

  typedef enum logic [1:0] {
    BR_NEXT,
    BR_CLEAR,
    BR_ALWAYS
  } br_e;

  typedef struct packed {
    wait_e    wt;
    dp_op_e   op;
    mul_sel_e msel;
    logic     mul_go;
    logic     div_go;
    br_e      br;
    step_t    tgt;
  } ucode_t;

  typedef struct packed {
    logic in_valid;
    logic in_mode;
    logic mul_done;
    logic div_done;
    logic out_free;
  } seq_cond_t;

  typedef struct packed {
    ucode_t uc;
    logic   fire;
    logic   idle;
  } seq_ctl_t;

  // control program: one word per step
  function automatic ucode_t ucode_rom(step_t s);
    ucode_t w;
    w.wt     = WT_NONE;
    w.op     = OP_NOP;
    w.msel   = MS_ERR_TS;
    w.mul_go = 1'b0;
    w.div_go = 1'b0;
    w.br     = BR_NEXT;
    w.tgt    = ST_IDLE;
    unique case (s)
      step_t'(0): begin
        w.wt = WT_IN;
        w.op = OP_LOAD_ERR;
        w.br = BR_CLEAR;
      end
      step_t'(1): begin
        w.msel   = MS_ERR_TS;
        w.mul_go = 1'b1;
        w.div_go = 1'b1;
      end
      step_t'(2): begin
        w.wt = WT_MUL;
        w.op = OP_INTEG_ADD;
      end
      step_t'(3): w.op = OP_INTEG_CLAMP;
      step_t'(4): begin
        w.msel   = MS_KP_ERR;
        w.mul_go = 1'b1;
      end
      step_t'(5): begin
        w.wt = WT_MUL;
        w.op = OP_ACC_LOAD;
      end
      step_t'(6): begin
        w.msel   = MS_KI_INTEG;
        w.mul_go = 1'b1;
      end
      step_t'(7): begin
        w.wt = WT_MUL;
        w.op = OP_ACC_ADD;
      end
      step_t'(8): begin
        w.wt = WT_DIV;
        w.op = OP_DERIV_LOAD;
      end
      step_t'(9): begin
        w.msel   = MS_KD_DERIV;
        w.mul_go = 1'b1;
      end
      step_t'(10): begin
        w.wt = WT_MUL;
        w.op = OP_ACC_ADD;
      end
      step_t'(11): w.op = OP_OUT_CLAMP;
      step_t'(12): begin
        w.wt = WT_OUT;
        w.op = OP_EMIT;
        w.br = BR_ALWAYS;
      end
      default: w.br = BR_ALWAYS;
    endcase
    return w;
  endfunction

endpackage

[design/pcc_mul.sv]
// Digit-serial signed fixed-point multiplier: 16 bits of one operand a cycle,
// floor shift by FRAC_BITS and saturation in a final state. Uses no package.
module pcc_mul #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         go_i,
  input  logic signed [DATA_WIDTH-1:0] a_i,
  input  logic signed [DATA_WIDTH-1:0] b_i,
  output logic signed [DATA_WIDTH-1:0] res_o,
  output logic                         valid_o
);

  localparam int W   = DATA_WIDTH;
  localparam int DGW = 16;
  localparam int ND  = (W + DGW - 1) / DGW;
  localparam int PW  = ND * DGW;
  localparam int AW  = W + PW;
  localparam int CW  = $clog2(ND + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  localparam logic [AW:0] PMAX = (AW+1)'({(W-1){1'b1}});
  localparam logic [AW:0] NMAX = PMAX + (AW+1)'(1);
  localparam logic [AW-1:0] DROP_MASK = (AW'(1) << FRAC_BITS) - AW'(1);

  logic [1:0]        state_q, state_d;
  logic [CW-1:0]     cnt_q;
  logic              valid_q;
  logic [AW-1:0]     acc_q;
  logic [PW-1:0]     mbs_q;
  logic [W-1:0]      ma_q;
  logic              neg_q;
  logic signed [W-1:0] res_q;

  logic [W-1:0]      ua, ub, ma, mb;
  logic [W+DGW-1:0]  pp;
  logic [AW-1:0]     sh;
  logic              dropped;
  logic [AW:0]       mag_r;
  logic signed [W-1:0] sat_res;

  assign ua = a_i;
  assign ub = b_i;
  assign ma = ua[W-1] ? (~ua + W'(1)) : ua;
  assign mb = ub[W-1] ? (~ub + W'(1)) : ub;

  assign pp = {{DGW{1'b0}}, ma_q} * {{W{1'b0}}, mbs_q[PW-1 -: DGW]};

  // floor on the magnitude: a negative product with dropped bits rounds away
  assign sh      = acc_q >> FRAC_BITS;
  assign dropped = |(acc_q & DROP_MASK);
  assign mag_r   = {1'b0, sh} + (AW+1)'(neg_q && dropped);

  always_comb begin
    if (!neg_q) begin
      sat_res = (mag_r > PMAX) ? {1'b0, {(W-1){1'b1}}} : mag_r[W-1:0];
    end else begin
      sat_res = (mag_r > NMAX) ? {1'b1, {(W-1){1'b0}}} : (~mag_r[W-1:0] + W'(1));
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (go_i) state_d = S_RUN;
      S_RUN:  if (cnt_q == CW'(1)) state_d = S_FIN;
      S_FIN:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_IDLE && go_i) begin
        cnt_q   <= CW'(ND);
        valid_q <= 1'b0;
      end else if (state_q == S_RUN) begin
        cnt_q <= cnt_q - CW'(1);
      end else if (state_q == S_FIN) begin
        valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && go_i) begin
      acc_q <= '0;
      ma_q  <= ma;
      mbs_q <= PW'(mb);
      neg_q <= ua[W-1] ^ ub[W-1];
    end else if (state_q == S_RUN) begin
      acc_q <= (acc_q << DGW) + AW'(pp);
      mbs_q <= mbs_q << DGW;
    end else if (state_q == S_FIN) begin
      res_q <= sat_res;
    end
  end

  assign res_o   = res_q;
  assign valid_o = valid_q;

endmodule

[design/pcc_div.sv]
// Bit-serial restoring divider: (num << FRAC_BITS) / den, truncated toward
// zero and saturated, one quotient bit a cycle. Uses no package.
module pcc_div #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         go_i,
  input  logic signed [DATA_WIDTH-1:0] num_i,
  input  logic        [DATA_WIDTH-2:0] den_i,
  output logic signed [DATA_WIDTH-1:0] res_o,
  output logic                         valid_o
);

  localparam int W  = DATA_WIDTH;
  localparam int DB = W + FRAC_BITS;
  localparam int CW = $clog2(DB + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  localparam logic [DB-1:0] QPMAX = DB'({(W-1){1'b1}});
  localparam logic [DB-1:0] QNMAX = QPMAX + DB'(1);
  localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

  logic [1:0]          state_q, state_d;
  logic [CW-1:0]       cnt_q;
  logic                valid_q;
  logic [DB-1:0]       dq_q;
  logic [W-1:0]        rem_q;
  logic [W-2:0]        den_q;
  logic                neg_q;
  logic signed [W-1:0] res_q;

  logic [W-1:0]        un, mn, r2;
  logic                ge;
  logic                zero_den;
  logic signed [W-1:0] zero_res;
  logic signed [W-1:0] sat_res;

  assign un = num_i;
  assign mn = un[W-1] ? (~un + W'(1)) : un;
  assign zero_den = (den_i == '0);
  assign zero_res = un[W-1] ? VMIN : ((un == '0) ? '0 : VMAX);

  assign r2 = {rem_q[W-2:0], dq_q[DB-1]};
  assign ge = (r2 >= {1'b0, den_q});

  always_comb begin
    if (!neg_q) begin
      sat_res = (dq_q > QPMAX) ? VMAX : dq_q[W-1:0];
    end else begin
      sat_res = (dq_q > QNMAX) ? VMIN : (~dq_q[W-1:0] + W'(1));
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (go_i && !zero_den) state_d = S_RUN;
      S_RUN:  if (cnt_q == CW'(1)) state_d = S_FIN;
      S_FIN:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_IDLE && go_i) begin
        cnt_q   <= CW'(DB);
        // zero period: result is known at once
        valid_q <= zero_den;
      end else if (state_q == S_RUN) begin
        cnt_q <= cnt_q - CW'(1);
      end else if (state_q == S_FIN) begin
        valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && go_i) begin
      dq_q  <= DB'(mn) << FRAC_BITS;
      rem_q <= '0;
      den_q <= den_i;
      neg_q <= un[W-1];
      res_q <= zero_res;
    end else if (state_q == S_RUN) begin
      rem_q <= ge ? (r2 - {1'b0, den_q}) : r2;
      dq_q  <= {dq_q[DB-2:0], ge};
    end else if (state_q == S_FIN) begin
      res_q <= sat_res;
    end
  end

  assign res_o   = res_q;
  assign valid_o = valid_q;

endmodule

[design/pcc_seq.sv]
// Microcode sequencer: step counter, control ROM lookup, wait conditions and
// jumps. Depends on pcc_pkg.
module pcc_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pcc_pkg::seq_cond_t cond_i,
  output pcc_pkg::seq_ctl_t  ctl_o
);

  import pcc_pkg::*;

  step_t  step_q, step_d;
  ucode_t uc;
  logic   met;

  assign uc = ucode_rom(step_q);

  always_comb begin
    unique case (uc.wt)
      WT_NONE: met = 1'b1;
      WT_IN:   met = cond_i.in_valid;
      WT_MUL:  met = cond_i.mul_done;
      WT_DIV:  met = cond_i.div_done;
      WT_OUT:  met = cond_i.out_free;
      default: met = 1'b0;
    endcase
  end

  always_comb begin
    step_d = step_q;
    if (met) begin
      unique case (uc.br)
        BR_ALWAYS: step_d = uc.tgt;
        BR_CLEAR:  step_d = cond_i.in_mode ? uc.tgt : step_q + step_t'(1);
        BR_NEXT:   step_d = step_q + step_t'(1);
        default:   step_d = ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ST_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  assign ctl_o.uc   = uc;
  assign ctl_o.fire = met;
  assign ctl_o.idle = (step_q == ST_IDLE);

endmodule

[design/pid_controller_clamped.sv]
// Clamped PID controller, signed fixed point, microcoded over one multiplier
// and one divider. Depends on pcc_pkg, pcc_seq, pcc_mul, pcc_div and macros.
// A compute word is accepted only while the sequencer is idle, and in_stall_o
// holds off the next word until the drive word is emitted; a clear word leaves
// it idle. Reset: gains zero, period 655, limits open, integral and last error
// zero; no clearing pass.
module pid_controller_clamped #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [pcc_pkg::REG_W-1:0]       cfg_addr_i,
  input  logic [DATA_WIDTH-1:0]           cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            mode_i,
  input  logic signed [DATA_WIDTH-1:0]    target_i,
  input  logic signed [DATA_WIDTH-1:0]    measured_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [DATA_WIDTH-1:0]    drive_o
);

  import pcc_pkg::*;

  `include "pid_controller_clamped_macros.svh"

  localparam int W = DATA_WIDTH;
  localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

  // configuration
  logic signed [W-1:0] kp_q, ki_q, kd_q;
  logic        [W-2:0] ts_q;
  logic signed [W-1:0] iu_q, il_q, ou_q, ol_q;

  // datapath
  logic signed [W-1:0] err_q, integ_q, last_err_q, acc_q, deriv_q, drive_q;
  logic                out_valid_q;

  seq_cond_t cond;
  seq_ctl_t  ctl;

  logic signed [W-1:0] mul_a, mul_b, mul_res, div_res;
  logic                mul_valid, div_valid;
  logic signed [W-1:0] new_err, err_diff, sum_integ, sum_acc;
  logic                clear_fire, start_fire, emit_fire;

  function automatic logic signed [W-1:0] sat_w(logic signed [W:0] x);
    if (x[W] != x[W-1]) begin
      return x[W] ? VMIN : VMAX;
    end
    return x[W-1:0];
  endfunction

  function automatic logic signed [W-1:0] sat_add(logic signed [W-1:0] a,
                                                  logic signed [W-1:0] b);
    return sat_w({a[W-1], a} + {b[W-1], b});
  endfunction

  function automatic logic signed [W-1:0] sat_sub(logic signed [W-1:0] a,
                                                  logic signed [W-1:0] b);
    return sat_w({a[W-1], a} - {b[W-1], b});
  endfunction

  // upper test wins when the limits cross
  function automatic logic signed [W-1:0] clamp(logic signed [W-1:0] v,
                                                logic signed [W-1:0] up,
                                                logic signed [W-1:0] lo);
    if (v > up) begin
      return up;
    end
    if (v < lo) begin
      return lo;
    end
    return v;
  endfunction

  assign cond.in_valid = in_valid_i;
  assign cond.in_mode  = mode_i;
  assign cond.mul_done = mul_valid;
  assign cond.div_done = div_valid;
  assign cond.out_free = !out_valid_q || !out_stall_i;

  pcc_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cond_i (cond),
    .ctl_o  (ctl)
  );

  always_comb begin
    unique case (ctl.uc.msel)
      MS_ERR_TS: begin
        mul_a = err_q;
        mul_b = {1'b0, ts_q};
      end
      MS_KP_ERR: begin
        mul_a = kp_q;
        mul_b = err_q;
      end
      MS_KI_INTEG: begin
        mul_a = ki_q;
        mul_b = integ_q;
      end
      MS_KD_DERIV: begin
        mul_a = kd_q;
        mul_b = deriv_q;
      end
      default: begin
        mul_a = err_q;
        mul_b = err_q;
      end
    endcase
  end

  assign err_diff = sat_sub(err_q, last_err_q);

  pcc_mul #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .go_i    (ctl.fire && ctl.uc.mul_go),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .res_o   (mul_res),
    .valid_o (mul_valid)
  );

  pcc_div #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .go_i    (ctl.fire && ctl.uc.div_go),
    .num_i   (err_diff),
    .den_i   (ts_q),
    .res_o   (div_res),
    .valid_o (div_valid)
  );

  assign new_err   = sat_sub(target_i, measured_i);
  assign sum_integ = sat_add(integ_q, mul_res);
  assign sum_acc   = sat_add(acc_q, mul_res);

  assign clear_fire = ctl.fire && (ctl.uc.op == OP_LOAD_ERR) && mode_i;
  assign start_fire = ctl.fire && (ctl.uc.op == OP_LOAD_ERR) && !mode_i;
  assign emit_fire  = ctl.fire && (ctl.uc.op == OP_EMIT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q <= '0;
      ki_q <= '0;
      kd_q <= '0;
      ts_q <= (W-1)'(655);
      iu_q <= VMAX;
      il_q <= VMIN;
      ou_q <= VMAX;
      ol_q <= VMIN;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_PROP_GAIN:   kp_q <= cfg_wdata_i;
        REG_INTEG_GAIN:  ki_q <= cfg_wdata_i;
        REG_DERIV_GAIN:  kd_q <= cfg_wdata_i;
        REG_TIME_STEP:   ts_q <= cfg_wdata_i[W-2:0];
        REG_INTEG_UPPER: iu_q <= cfg_wdata_i;
        REG_INTEG_LOWER: il_q <= cfg_wdata_i;
        REG_OUT_UPPER:   ou_q <= cfg_wdata_i;
        REG_OUT_LOWER:   ol_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // controller state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q     <= '0;
      last_err_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (clear_fire) begin
        integ_q    <= '0;
        last_err_q <= '0;
      end else if (ctl.fire && ctl.uc.op == OP_INTEG_CLAMP) begin
        integ_q <= clamp(acc_q, iu_q, il_q);
      end else if (emit_fire) begin
        last_err_q <= err_q;
      end
      if (emit_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.fire) begin
      unique case (ctl.uc.op)
        OP_LOAD_ERR:   if (!mode_i) err_q <= new_err;
        OP_INTEG_ADD:  acc_q   <= sum_integ;
        OP_ACC_LOAD:   acc_q   <= mul_res;
        OP_ACC_ADD:    acc_q   <= sum_acc;
        OP_DERIV_LOAD: deriv_q <= div_res;
        OP_OUT_CLAMP:  acc_q   <= clamp(acc_q, ou_q, ol_q);
        OP_EMIT:       drive_q <= acc_q;
        default: ;
      endcase
    end
  end

  assign in_stall_o  = !ctl.idle;
  assign out_valid_o = out_valid_q;
  assign drive_o     = drive_q;

  `PCC_ASSERT_NEXT(a_clear_zeroes_state, clk_i, rst_ni, clear_fire,
                   integ_q == '0 && last_err_q == '0, "clear word left state")
  `PCC_ASSERT_NEXT(a_start_leaves_idle, clk_i, rst_ni, start_fire,
                   !ctl.idle, "compute word did not start program")
  `PCC_ASSERT_NOW(a_out_only_on_emit, clk_i, rst_ni, $rose(out_valid_q),
                  $past(emit_fire), "drive word without emit step")
  `PCC_ASSERT_NEXT(a_integ_in_limits, clk_i, rst_ni,
                   ctl.fire && ctl.uc.op == OP_INTEG_CLAMP,
                   integ_q == $past(iu_q) || integ_q == $past(il_q) ||
                   (integ_q <= $past(iu_q) && integ_q >= $past(il_q)),
                   "integral outside limits")

endmodule
